[design/f2d_pkg.sv]
// Package for the float-to-decimal-text block: shared constants, number and job types,
// multiplier handshake structs and the state enums of the back end.
// No dependencies.
package f2d_pkg;

    localparam int MAX_TEXT_CHARS = 48;
    localparam int SIG_DIGITS     = 9;
    localparam int QUEUE_DEPTH    = 2;
    localparam int DIG_MAX        = 10;
    localparam int POS_W          = 8;

    localparam logic [31:0] EIGHT_DIGIT_LIMIT = 32'd167772159;
    // floor(log10(2) * 2^22), used for the decimal exponent estimate.
    localparam logic [20:0] LOG10_2_Q22 = 21'd1262611;
    // ceil(2^35 / 10), exact division by ten for any 32-bit value.
    localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_DOT   = 7'h2E;

    // Unsigned binary64-style value: m * 2^e with 2^52 <= m < 2^53.
    typedef struct packed {
        logic [52:0]        m;
        logic signed [11:0] e;
    } t_dnum;

    localparam t_dnum DN_ONE   = '{m: 53'h10000000000000, e: -12'sd52};
    localparam t_dnum DN_TEN   = '{m: 53'h14000000000000, e: -12'sd49};
    localparam t_dnum DN_1E15  = '{m: 53'h1C6BF526340000, e: -12'sd3};
    localparam t_dnum DN_TENTH = '{m: 53'h1999999999999A, e: -12'sd56};

    typedef struct packed {
        logic               zero;
        logic               neg;
        t_dnum              val;
        logic signed [7:0]  shift;
    } t_job;

    typedef struct packed {
        logic  start;
        t_dnum a;
        t_dnum b;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

    typedef enum logic [3:0] {
        S_IDLE, S_PW_STEP, S_PW_MULW, S_PW_NEXT, S_PW_SQW, S_SCALE, S_SCALEW,
        S_CHECK, S_TEN, S_TENW, S_SC8, S_DIVM, S_DIVS, S_PREP, S_EMIT
    } t_bstate;

    typedef enum logic [2:0] {
        P_ZERO, P_SIGN, P_IDIG, P_TZERO, P_DOT, P_LZERO, P_FDIG
    } t_phase;

endpackage

[design/f2d_front.sv]
// Front end: classifies one binary32 pattern and normalizes it into a conversion job.
// Depends on f2d_pkg.
module f2d_front (
    input  logic [31:0]   i_float_bits,
    output f2d_pkg::t_job o_job
);

    localparam logic [20:0] LOG10_2_Q22_W = f2d_pkg::LOG10_2_Q22;

    logic [7:0]         ex, exc;
    logic [22:0]        fr, frc;
    logic               is_nan, is_inf;
    logic [4:0]         p;
    logic [5:0]         lsh;
    logic signed [8:0]  be;
    logic signed [30:0] prod;
    logic signed [6:0]  dexp;

    always_comb begin
        ex     = i_float_bits[30:23];
        fr     = i_float_bits[22:0];
        is_nan = (ex == 8'hFF) && (fr != 23'd0);
        is_inf = (ex == 8'hFF) && (fr == 23'd0);
        exc    = is_nan ? 8'd0 : (is_inf ? 8'hFE : ex);
        frc    = is_nan ? 23'd0 : (is_inf ? '1 : fr);

        p = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (frc[i]) begin
                p = 5'(i);
            end
        end
        lsh = 6'd52 - {1'b0, p};

        o_job.zero = (exc == 8'd0) && (frc == 23'd0);
        o_job.neg  = i_float_bits[31];
        if (exc != 8'd0) begin
            o_job.val.m = {1'b1, frc, 29'd0};
            o_job.val.e = $signed({4'd0, exc}) - 12'sd179;
            be          = $signed({1'b0, exc}) - 9'sd126;
        end else begin
            o_job.val.m = {30'd0, frc} << lsh;
            o_job.val.e = $signed({7'd0, p}) - 12'sd201;
            be          = $signed({4'd0, p}) - 9'sd148;
        end

        // Decimal exponent: floor(be * log10(2)).
        prod        = 31'(be) * $signed({10'd0, LOG10_2_Q22_W});
        dexp        = prod[28:22];
        o_job.shift = {dexp[6], dexp} - 8'(f2d_pkg::SIG_DIGITS - 1);
    end

endmodule

[design/f2d_fifo.sv]
// Short job queue between the front end and the back end.
// Depends on f2d_pkg.
module f2d_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  f2d_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_take,
    output f2d_pkg::t_job o_job,
    output logic          o_empty
);

    localparam int PTR_W = $clog2(f2d_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(f2d_pkg::QUEUE_DEPTH + 1);

    f2d_pkg::t_job    r_mem [f2d_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             wr, rd;

    assign o_full  = (r_cnt == CNT_W'(f2d_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_take && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (rd) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

[design/f2d_dmul.sv]
// Iterative 53x53 mantissa multiplier with round-to-nearest-even, one partial product
// per cycle. Depends on f2d_pkg.
module f2d_dmul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  f2d_pkg::t_mul_req  i_req,
    output f2d_pkg::t_mul_stat o_stat,
    output f2d_pkg::t_dnum     o_res
);

    logic               r_busy, r_done;
    logic [2:0]         r_step;
    logic [52:0]        r_a, r_b;
    logic signed [11:0] r_esum;
    logic [53:0]        r_pp;
    logic [105:0]       r_acc;
    f2d_pkg::t_dnum     r_res;

    logic [26:0]        a_op, b_op;
    logic [105:0]       pp_sh;
    logic               s53, guard, sticky, up;
    logic [52:0]        q;
    logic [53:0]        qr;
    f2d_pkg::t_dnum     n_res;

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_res;

    always_comb begin
        // Low halves are 27 bits, high halves 26 bits.
        a_op = (r_step == 3'd2 || r_step == 3'd3) ? {1'b0, r_a[52:27]} : r_a[26:0];
        b_op = (r_step == 3'd1 || r_step == 3'd3) ? {1'b0, r_b[52:27]} : r_b[26:0];

        // Partial product accumulated this cycle was formed in step r_step - 1.
        case (r_step)
            3'd2, 3'd3: pp_sh = {25'd0, r_pp, 27'd0};
            3'd4:       pp_sh = {r_pp[51:0], 54'd0};
            default:    pp_sh = {52'd0, r_pp};
        endcase

        s53    = r_acc[105];
        q      = s53 ? r_acc[105:53] : r_acc[104:52];
        guard  = s53 ? r_acc[52] : r_acc[51];
        sticky = s53 ? (|r_acc[51:0]) : (|r_acc[50:0]);
        up     = guard && (sticky || q[0]);
        qr     = {1'b0, q} + {53'd0, up};
        n_res.m = qr[53] ? qr[53:1] : qr[52:0];
        n_res.e = r_esum + (s53 ? 12'sd53 : 12'sd52) + (qr[53] ? 12'sd1 : 12'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_a    <= i_req.a.m;
            r_b    <= i_req.b.m;
            r_esum <= i_req.a.e + i_req.b.e;
            r_acc  <= '0;
        end else if (r_busy) begin
            if (r_step <= 3'd3) begin
                r_pp <= a_op * b_op;
            end
            if (r_step >= 3'd1 && r_step <= 3'd4) begin
                r_acc <= r_acc + pp_sh;
            end
            if (r_step == 3'd5) begin
                r_res <= n_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

endmodule

[design/f2d_back.sv]
// Back end: power-of-ten sequencing, scaling and rounding, digit extraction and the
// character emitter with its output register. Depends on f2d_pkg and f2d_dmul.
module f2d_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  f2d_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_take,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [6:0]    o_text_char,
    output logic          o_last_char
);

    f2d_pkg::t_bstate   r_state, n_state;
    logic               r_neg, r_eight, r_strip;
    f2d_pkg::t_dnum     r_val, r_pv, r_pb;
    logic signed [7:0]  r_shift, r_pbp;
    logic [5:0]         r_npow;
    logic [31:0]        r_d;
    logic [63:0]        r_prod;
    logic [3:0]         r_dig [f2d_pkg::DIG_MAX];
    logic [3:0]         r_nd;
    f2d_pkg::t_phase    r_phase;
    logic [7:0]         r_cnt;
    logic [f2d_pkg::POS_W-1:0] r_pos, r_len;
    logic [6:0]         r_char;
    logic               r_last, r_ovalid;

    f2d_pkg::t_mul_req  mreq;
    f2d_pkg::t_mul_stat mstat;
    f2d_pkg::t_dnum     mres;

    logic signed [7:0]  k;
    logic [31:0]        d_round, q10, rem32;
    logic [3:0]         rem;
    logic signed [7:0]  nd8, pbv, len_raw;
    logic               intm;
    f2d_pkg::t_phase    f_phase, e_phase;
    logic [7:0]         f_cnt, e_cnt;
    logic [6:0]         e_char;
    logic               e_pop;
    logic [3:0]         dig_idx;
    logic               adv, last_now, pop_out;

    f2d_dmul u_dmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_stat  (mstat),
        .o_res   (mres)
    );

    function automatic logic [31:0] round_away(f2d_pkg::t_dnum x);
        logic signed [11:0] ne;
        logic [6:0]         sh;
        logic [63:0]        sum;
        ne  = -x.e;
        sh  = ne[6:0];
        sum = {11'd0, x.m} + (64'd1 << (sh - 7'd1));
        if (x.e >= 12'sd0) begin
            return '1;
        end else if (x.e <= -12'sd64) begin
            return '0;
        end
        return 32'(sum >> sh);
    endfunction

    assign o_empty     = !r_ovalid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;
    assign pop_out     = i_pop && r_ovalid;
    assign adv         = (r_state == f2d_pkg::S_EMIT) && (!r_ovalid || i_pop);
    assign last_now    = (r_pos == r_len - f2d_pkg::POS_W'(1));
    assign o_take      = (r_state == f2d_pkg::S_IDLE) && i_job_valid;

    always_comb begin
        k       = -i_job.shift;
        d_round = round_away(mres);
        q10     = {3'd0, r_prod[63:35]};
        rem32   = r_d - ((q10 << 3) + (q10 << 1));
        rem     = rem32[3:0];
        nd8     = $signed({4'd0, r_nd});
        intm    = !r_shift[7];
        pbv     = nd8 + r_shift;
        if (intm) begin
            len_raw = nd8 + r_shift;
        end else if (pbv > 8'sd0) begin
            len_raw = nd8 + 8'sd1;
        end else begin
            len_raw = nd8 + 8'sd1 - pbv;
        end
        len_raw = len_raw + (r_neg ? 8'sd1 : 8'sd0);
        if (intm || pbv > 8'sd0) begin
            f_phase = f2d_pkg::P_IDIG;
        end else begin
            f_phase = f2d_pkg::P_DOT;
        end
        f_cnt = intm ? {4'd0, r_nd} : pbv;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            f2d_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.zero ? f2d_pkg::S_EMIT : f2d_pkg::S_PW_STEP;
                end
            end
            f2d_pkg::S_PW_STEP: begin
                n_state = r_npow[0] ? f2d_pkg::S_PW_MULW : f2d_pkg::S_PW_NEXT;
            end
            f2d_pkg::S_PW_MULW: begin
                if (mstat.done) begin
                    n_state = f2d_pkg::S_PW_NEXT;
                end
            end
            f2d_pkg::S_PW_NEXT: begin
                n_state = (r_npow[5:1] == 5'd0) ? f2d_pkg::S_SCALE : f2d_pkg::S_PW_SQW;
            end
            f2d_pkg::S_PW_SQW: begin
                if (mstat.done) begin
                    n_state = f2d_pkg::S_PW_STEP;
                end
            end
            f2d_pkg::S_SCALE:  n_state = f2d_pkg::S_SCALEW;
            f2d_pkg::S_SCALEW: begin
                if (mstat.done) begin
                    n_state = f2d_pkg::S_CHECK;
                end
            end
            f2d_pkg::S_CHECK: begin
                if (!r_eight && r_d > f2d_pkg::EIGHT_DIGIT_LIMIT) begin
                    n_state = f2d_pkg::S_TEN;
                end else begin
                    n_state = f2d_pkg::S_DIVM;
                end
            end
            f2d_pkg::S_TEN:  n_state = f2d_pkg::S_TENW;
            f2d_pkg::S_TENW: begin
                if (mstat.done) begin
                    n_state = f2d_pkg::S_SC8;
                end
            end
            f2d_pkg::S_SC8:  n_state = f2d_pkg::S_SCALEW;
            f2d_pkg::S_DIVM: n_state = f2d_pkg::S_DIVS;
            f2d_pkg::S_DIVS: begin
                if (!(r_strip && r_d != 32'd0 && rem == 4'd0) && q10 == 32'd0) begin
                    n_state = f2d_pkg::S_PREP;
                end else begin
                    n_state = f2d_pkg::S_DIVM;
                end
            end
            f2d_pkg::S_PREP: n_state = f2d_pkg::S_EMIT;
            f2d_pkg::S_EMIT: begin
                if (adv && last_now) begin
                    n_state = f2d_pkg::S_IDLE;
                end
            end
            default: n_state = f2d_pkg::S_IDLE;
        endcase
    end

    // Multiplier requests and the next character.
    always_comb begin
        mreq.start = 1'b0;
        mreq.a     = r_pv;
        mreq.b     = r_pb;
        unique case (r_state)
            f2d_pkg::S_PW_STEP: mreq.start = r_npow[0];
            f2d_pkg::S_PW_NEXT: begin
                mreq.start = (r_npow[5:1] != 5'd0);
                mreq.a     = r_pb;
            end
            f2d_pkg::S_SCALE: begin
                mreq.start = 1'b1;
                mreq.a     = r_val;
                mreq.b     = r_pv;
            end
            f2d_pkg::S_TEN: begin
                mreq.start = 1'b1;
                mreq.b     = f2d_pkg::DN_TENTH;
            end
            f2d_pkg::S_SC8: begin
                mreq.start = 1'b1;
                mreq.a     = r_val;
            end
            default: mreq.start = 1'b0;
        endcase

        dig_idx = r_nd - 4'd1;
        e_char  = f2d_pkg::CH_ZERO;
        e_phase = r_phase;
        e_cnt   = r_cnt - 8'd1;
        e_pop   = 1'b0;
        unique case (r_phase)
            f2d_pkg::P_ZERO: e_char = f2d_pkg::CH_ZERO;
            f2d_pkg::P_SIGN: begin
                e_char  = f2d_pkg::CH_MINUS;
                e_phase = f_phase;
                e_cnt   = f_cnt;
            end
            f2d_pkg::P_IDIG: begin
                e_char = f2d_pkg::CH_ZERO + {3'd0, r_dig[dig_idx]};
                e_pop  = 1'b1;
                if (r_cnt == 8'd1) begin
                    e_phase = intm ? f2d_pkg::P_TZERO : f2d_pkg::P_DOT;
                    e_cnt   = r_shift;
                end
            end
            f2d_pkg::P_TZERO: e_char = f2d_pkg::CH_ZERO;
            f2d_pkg::P_DOT: begin
                e_char = f2d_pkg::CH_DOT;
                if (r_pbp >= 8'sd0) begin
                    e_phase = f2d_pkg::P_FDIG;
                end else begin
                    e_phase = f2d_pkg::P_LZERO;
                    e_cnt   = -r_pbp;
                end
            end
            f2d_pkg::P_LZERO: begin
                e_char = f2d_pkg::CH_ZERO;
                if (r_cnt == 8'd1) begin
                    e_phase = f2d_pkg::P_FDIG;
                end
            end
            f2d_pkg::P_FDIG: begin
                e_char = f2d_pkg::CH_ZERO + {3'd0, r_dig[dig_idx]};
                e_pop  = 1'b1;
            end
            default: e_char = f2d_pkg::CH_ZERO;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            f2d_pkg::S_IDLE: begin
                r_neg   <= i_job.neg && !i_job.zero;
                r_val   <= i_job.val;
                r_shift <= i_job.shift;
                r_eight <= 1'b0;
                r_nd    <= 4'd0;
                r_pos   <= '0;
                r_len   <= f2d_pkg::POS_W'(1);
                r_phase <= f2d_pkg::P_ZERO;
                if (k > 8'sd15) begin
                    r_pv   <= f2d_pkg::DN_1E15;
                    r_pb   <= f2d_pkg::DN_TEN;
                    r_npow <= 6'(k - 8'sd15);
                end else if (k >= 8'sd0) begin
                    r_pv   <= f2d_pkg::DN_ONE;
                    r_pb   <= f2d_pkg::DN_TEN;
                    r_npow <= 6'(k);
                end else begin
                    r_pv   <= f2d_pkg::DN_ONE;
                    r_pb   <= f2d_pkg::DN_TENTH;
                    r_npow <= 6'(-k);
                end
            end
            f2d_pkg::S_PW_MULW: begin
                if (mstat.done) begin
                    r_pv <= mres;
                end
            end
            f2d_pkg::S_PW_NEXT: r_npow <= r_npow >> 1;
            f2d_pkg::S_PW_SQW: begin
                if (mstat.done) begin
                    r_pb <= mres;
                end
            end
            f2d_pkg::S_SCALEW: begin
                if (mstat.done) begin
                    r_d <= d_round;
                end
            end
            f2d_pkg::S_CHECK: begin
                r_strip <= 1'b1;
                r_nd    <= 4'd0;
                if (!r_eight && r_d > f2d_pkg::EIGHT_DIGIT_LIMIT) begin
                    r_eight <= 1'b1;
                    r_shift <= r_shift + 8'sd1;
                end
            end
            f2d_pkg::S_TENW: begin
                if (mstat.done) begin
                    r_pb <= mres;
                end
            end
            f2d_pkg::S_DIVM: r_prod <= r_d * f2d_pkg::RECIP_TEN;
            f2d_pkg::S_DIVS: begin
                r_d <= q10;
                if (r_strip && r_d != 32'd0 && rem == 4'd0) begin
                    r_shift <= r_shift + 8'sd1;
                end else begin
                    r_strip      <= 1'b0;
                    r_dig[r_nd]  <= rem;
                    r_nd         <= r_nd + 4'd1;
                end
            end
            f2d_pkg::S_PREP: begin
                r_pbp   <= pbv;
                r_cnt   <= f_cnt;
                r_phase <= r_neg ? f2d_pkg::P_SIGN : f_phase;
                if (len_raw > $signed(8'(f2d_pkg::MAX_TEXT_CHARS))) begin
                    r_len <= f2d_pkg::POS_W'(f2d_pkg::MAX_TEXT_CHARS);
                end else begin
                    r_len <= len_raw;
                end
            end
            f2d_pkg::S_EMIT: begin
                if (adv) begin
                    r_char  <= e_char;
                    r_last  <= last_now;
                    r_pos   <= r_pos + f2d_pkg::POS_W'(1);
                    r_phase <= e_phase;
                    r_cnt   <= e_cnt;
                    if (e_pop) begin
                        r_nd <= r_nd - 4'd1;
                    end
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= f2d_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (pop_out) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mreq.start |-> !mstat.busy)
        else $error("multiplier started while busy");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mstat.done |-> (r_state == f2d_pkg::S_PW_MULW || r_state == f2d_pkg::S_PW_SQW ||
                        r_state == f2d_pkg::S_SCALEW || r_state == f2d_pkg::S_TENW))
        else $error("multiplier result arrived outside a wait state");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nd <= 4'(f2d_pkg::DIG_MAX))
        else $error("digit count overflow");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == f2d_pkg::S_EMIT) |-> (r_pos < r_len))
        else $error("character position past text length");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && last_now) |=> (r_state == f2d_pkg::S_IDLE && r_last))
        else $error("final character did not end the item");

endmodule

[design/float_to_fixed_decimal_text.sv]
// Top level of the float-to-decimal-text converter: front end, job queue and back end.
// Depends on f2d_pkg, f2d_front, f2d_fifo, f2d_back (and f2d_dmul below it).
//
//  Channel   Handshake        Payload                       Direction
//  input     push / full      i_float_bits[31:0]            into the block
//  result    empty / pop      o_text_char[6:0], o_last_char out of the block
//
// An accepted beat is classified and normalized in the same cycle and parked in a
// two-entry job queue, so the input side keeps taking beats while the back end works.
// The back end converts one job at a time: the power of ten takes up to nine
// multiplies by binary powering, then one or three more for scaling, each issued from
// its own state to the shared 53x53 multiplier; digit extraction takes a divide step
// (S_DIVM, then S_DIVS) per digit or stripped zero. Characters then leave at one per
// cycle through the output register while the result side pops. A zero skips straight
// to the emitter; for any other item the multiplier and the text length set the time.
// Reset is synchronous and active low; it empties the queue and the output register.
// A stalled result side holds the back end but not the front until the queue fills.
module float_to_fixed_decimal_text (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_float_bits,
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  o_text_char,
    output logic        o_last_char
);

    f2d_pkg::t_job front_job, queue_job;
    logic          queue_empty, take;

    // Decode, special cases and decimal exponent estimate.
    f2d_front u_front (
        .i_float_bits (i_float_bits),
        .o_job        (front_job)
    );

    // Decouples acceptance from the long conversion.
    f2d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_take  (take),
        .o_job   (queue_job),
        .o_empty (queue_empty)
    );

    // Scaling, rounding, digits and the character stream.
    f2d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (queue_job),
        .i_job_valid (!queue_empty),
        .o_take      (take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule
